// ----- hw/rtl/vpp_pkg.sv -----
// ============================================================================
// vpp_pkg
// Shared types for the vector plane projection block.
// ============================================================================
`default_nettype none

package vpp_pkg;

    // pipeline step control handed to each divider cell
    typedef struct packed {
        logic en;     // whole pipe advances this cycle
        logic valid;  // the transaction entering the cell is live
    } pipe_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vpp_div_cell.sv -----
// ============================================================================
// vpp_div_cell
// One restoring-division step for three lanes that share a divisor. The cell
// settles quotient bit SHIFT and hands remainder, quotient and sideband on.
// ============================================================================
`default_nettype none

module vpp_div_cell #(
    parameter int REM_W  = 81,
    parameter int DEN_W  = 64,
    parameter int QW     = 17,
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 52
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  vpp_pkg::pipe_ctl_t     ctl,
    input  wire  [DEN_W-1:0]       den_in,
    input  wire  [3*REM_W-1:0]     rem_in,
    input  wire  [3*QW-1:0]        quo_in,
    input  wire  [SIDE_W-1:0]      side_in,
    output logic                   valid_out,
    output logic [DEN_W-1:0]       den_out,
    output logic [3*REM_W-1:0]     rem_out,
    output logic [3*QW-1:0]        quo_out,
    output logic [SIDE_W-1:0]      side_out
);
    import vpp_pkg::*;

    logic [REM_W-1:0]   den_sh;
    logic [3*REM_W-1:0] rem_next;
    logic [3*QW-1:0]    quo_next;

    assign den_sh = REM_W'(den_in) << SHIFT;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (rem_in[i*REM_W +: REM_W] >= den_sh)
            begin
                rem_next[i*REM_W +: REM_W] = rem_in[i*REM_W +: REM_W] - den_sh;
                quo_next[i*QW +: QW] = quo_in[i*QW +: QW] | (QW'(1) << SHIFT);
            end
            else
            begin
                rem_next[i*REM_W +: REM_W] = rem_in[i*REM_W +: REM_W];
                quo_next[i*QW +: QW] = quo_in[i*QW +: QW];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out <= 1'b0;
        end
        else if (ctl.en)
        begin
            valid_out <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            den_out  <= den_in;
            rem_out  <= rem_next;
            quo_out  <= quo_next;
            side_out <= side_in;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/vector_plane_projection.sv -----
// ============================================================================
// vector_plane_projection
// Projects a 3D vector onto the plane spanned by two vectors.
// ============================================================================
// Usage:
//   Slave channel s_*: one transaction carries v, a and b (nine signed words).
//   Master channel m_*: one transaction per input carries the projection
//   p = v - n*(n.v)/(n.n), n = a x b, quotient truncated toward zero, and
//   tuser = degenerate (n is zero, v passed through sign-extended).
//   Pipeline: six arithmetic stages, one divider cell per quotient bit
//   (DATA_WIDTH+1 cells), and the output register.
//   Throughput: one transaction per cycle unless stalled; the divider is
//   a chain of cells, one per quotient bit, so every stage holds its own item.
//   Stall: when the output register holds an untaken result, the whole pipe
//   freezes and s_tready drops in the same cycle; nothing is lost.
//   Reset: clears all stage valid flags; the pipe comes up empty and ready.
// ============================================================================
`default_nettype none

module vector_plane_projection #(
    parameter int DATA_WIDTH = 16
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     s_tvalid,
    output logic                                    s_tready,
    // vec_x, vec_y, vec_z, plane_a_x/y/z, plane_b_x/y/z, zero pad
    input  wire  [((9*DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                    m_tvalid,
    input  wire                                     m_tready,
    // proj_x, proj_y, proj_z, zero pad
    output logic [((3*(DATA_WIDTH+2)+7)/8)*8-1:0]   m_tdata,
    // degenerate
    output logic [0:0]                              m_tuser
);
    import vpp_pkg::*;

    localparam int DW     = DATA_WIDTH;
    localparam int PW     = 2*DW;
    localparam int NW     = 2*DW + 1;
    localparam int MW     = 2*DW;
    localparam int NN_W   = 4*DW;
    localparam int DVW    = 3*DW + 1;
    localparam int DVM    = 3*DW;
    localparam int HALF   = (DVM + 1) / 2;
    localparam int HI     = DVM - HALF;
    localparam int NUM_W  = 5*DW;
    localparam int REM_W  = NUM_W + 1;
    localparam int QW     = DW + 1;
    localparam int OUT_W  = DW + 2;
    localparam int SIDE_W = 3*DW + 4;
    localparam int OD_W   = ((3*OUT_W+7)/8)*8;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: cross-product terms ----------------
    logic                 s1_valid_reg;
    logic signed [PW-1:0] s1_p_reg [6];
    logic [3*DW-1:0]      s1_v_reg;

    logic signed [DW-1:0] ia [3];
    logic signed [DW-1:0] ib [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ia[i] = s_tdata[(3+i)*DW +: DW];
            ib[i] = s_tdata[(6+i)*DW +: DW];
        end
    end

    // ---------------- stage 2: normal ----------------
    logic                 s2_valid_reg;
    logic signed [NW-1:0] s2_n_reg [3];
    logic [3*DW-1:0]      s2_v_reg;

    // ---------------- stage 3: squares, n*v, magnitudes ----------------
    logic                  s3_valid_reg;
    logic [NN_W-1:0]       s3_sq_reg [3];
    logic signed [DVW-1:0] s3_nv_reg [3];
    logic [MW-1:0]         s3_mn_reg [3];
    logic [2:0]            s3_nneg_reg;
    logic [3*DW-1:0]       s3_v_reg;

    // ---------------- stage 4: n.n and n.v ----------------
    logic                  s4_valid_reg;
    logic [NN_W-1:0]       s4_nn_reg;
    logic signed [DVW-1:0] s4_dv_reg;
    logic [MW-1:0]         s4_mn_reg [3];
    logic [2:0]            s4_nneg_reg;
    logic [3*DW-1:0]       s4_v_reg;

    // ---------------- stage 5: split numerator products ----------------
    logic                 s5_valid_reg;
    logic [MW+HALF-1:0]   s5_plo_reg [3];
    logic [MW+HI-1:0]     s5_phi_reg [3];
    logic [NN_W-1:0]      s5_den_reg;
    logic [SIDE_W-1:0]    s5_side_reg;

    logic [DVM-1:0] dv_mag;
    logic [DVW-1:0] dv_neg_val;
    assign dv_neg_val = -s4_dv_reg;
    assign dv_mag = s4_dv_reg[DVW-1] ? dv_neg_val[DVM-1:0] : s4_dv_reg[DVM-1:0];

    // ---------------- stage 6: numerators ----------------
    logic                 s6_valid_reg;
    logic [3*REM_W-1:0]   s6_num_reg;
    logic [NN_W-1:0]      s6_den_reg;
    logic [SIDE_W-1:0]    s6_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_p_reg[0] <= ia[1] * ib[2];
            s1_p_reg[1] <= ia[2] * ib[1];
            s1_p_reg[2] <= ia[2] * ib[0];
            s1_p_reg[3] <= ia[0] * ib[2];
            s1_p_reg[4] <= ia[0] * ib[1];
            s1_p_reg[5] <= ia[1] * ib[0];
            s1_v_reg    <= s_tdata[3*DW-1:0];

            for (int i = 0; i < 3; i++)
            begin
                s2_n_reg[i] <= NW'(s1_p_reg[2*i]) - NW'(s1_p_reg[2*i+1]);
            end
            s2_v_reg <= s1_v_reg;

            for (int i = 0; i < 3; i++)
            begin
                s3_sq_reg[i] <= NN_W'($signed(s2_n_reg[i]) * $signed(s2_n_reg[i]));
                s3_nv_reg[i] <= s2_n_reg[i] * $signed(s2_v_reg[i*DW +: DW]);
                s3_mn_reg[i] <= s2_n_reg[i][NW-1] ? MW'(-s2_n_reg[i]) : MW'(s2_n_reg[i]);
                s3_nneg_reg[i] <= s2_n_reg[i][NW-1];
            end
            s3_v_reg <= s2_v_reg;

            s4_nn_reg   <= s3_sq_reg[0] + s3_sq_reg[1] + s3_sq_reg[2];
            s4_dv_reg   <= s3_nv_reg[0] + s3_nv_reg[1] + s3_nv_reg[2];
            s4_mn_reg   <= s3_mn_reg;
            s4_nneg_reg <= s3_nneg_reg;
            s4_v_reg    <= s3_v_reg;

            for (int i = 0; i < 3; i++)
            begin
                s5_plo_reg[i] <= s4_mn_reg[i] * dv_mag[HALF-1:0];
                s5_phi_reg[i] <= s4_mn_reg[i] * dv_mag[DVM-1:HALF];
            end
            s5_den_reg  <= s4_nn_reg;
            s5_side_reg <= {(s4_nn_reg == '0),
                            s4_nneg_reg ^ {3{s4_dv_reg[DVW-1]}},
                            s4_v_reg};

            for (int i = 0; i < 3; i++)
            begin
                s6_num_reg[i*REM_W +: REM_W] <= (REM_W'(s5_phi_reg[i]) << HALF)
                                               + REM_W'(s5_plo_reg[i]);
            end
            s6_den_reg  <= s5_den_reg;
            s6_side_reg <= s5_side_reg;
        end
    end

    // ---------------- divider chain ----------------
    logic               c_valid [QW+1];
    logic [NN_W-1:0]    c_den   [QW+1];
    logic [3*REM_W-1:0] c_rem   [QW+1];
    logic [3*QW-1:0]    c_quo   [QW+1];
    logic [SIDE_W-1:0]  c_side  [QW+1];

    assign c_valid[0] = s6_valid_reg;
    assign c_den[0]   = s6_den_reg;
    assign c_rem[0]   = s6_num_reg;
    assign c_quo[0]   = '0;
    assign c_side[0]  = s6_side_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_cell
        pipe_ctl_t ctl;
        assign ctl.en    = en;
        assign ctl.valid = c_valid[j];

        vpp_div_cell #(
            .REM_W  (REM_W),
            .DEN_W  (NN_W),
            .QW     (QW),
            .SHIFT  (QW - 1 - j),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .den_in    (c_den[j]),
            .rem_in    (c_rem[j]),
            .quo_in    (c_quo[j]),
            .side_in   (c_side[j]),
            .valid_out (c_valid[j+1]),
            .den_out   (c_den[j+1]),
            .rem_out   (c_rem[j+1]),
            .quo_out   (c_quo[j+1]),
            .side_out  (c_side[j+1])
        );
    end

    // ---------------- output stage ----------------
    logic                  d_degen;
    logic [2:0]            d_neg;
    logic [3*OUT_W-1:0]    res;
    logic signed [QW:0]    qs   [3];
    logic signed [OUT_W:0] diff [3];
    logic signed [DW-1:0]  vv   [3];

    assign d_degen = c_side[QW][SIDE_W-1];
    assign d_neg   = c_side[QW][3*DW +: 3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vv[i] = c_side[QW][i*DW +: DW];
            qs[i] = $signed({1'b0, c_quo[QW][i*QW +: QW]});
            if (d_neg[i])
            begin
                qs[i] = -qs[i];
            end
            if (d_degen)
            begin
                diff[i] = (OUT_W+1)'(vv[i]);
            end
            else
            begin
                diff[i] = (OUT_W+1)'(vv[i]) - (OUT_W+1)'(qs[i]);
            end
            if (diff[i] > $signed((OUT_W+1)'((1 << (OUT_W-1)) - 1)))
            begin
                res[i*OUT_W +: OUT_W] = {1'b0, {(OUT_W-1){1'b1}}};
            end
            else if (diff[i] < -$signed((OUT_W+1)'(1 << (OUT_W-1))))
            begin
                res[i*OUT_W +: OUT_W] = {1'b1, {(OUT_W-1){1'b0}}};
            end
            else
            begin
                res[i*OUT_W +: OUT_W] = diff[i][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid <= c_valid[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata <= OD_W'(res);
            m_tuser <= d_degen;
        end
    end

    // ---------------- checks ----------------
    // divider finished: every remainder of a non-degenerate item is below the divisor
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid[QW] && !d_degen |->
            c_rem[QW][0 +: REM_W] < REM_W'(c_den[QW]) &&
            c_rem[QW][REM_W +: REM_W] < REM_W'(c_den[QW]) &&
            c_rem[QW][2*REM_W +: REM_W] < REM_W'(c_den[QW]))
        else $error("divider remainder not below divisor");

    // zero normal gives zero low-half numerator products
    a_degen_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg && s5_side_reg[SIDE_W-1] |->
            s5_plo_reg[0] == '0 && s5_plo_reg[1] == '0 && s5_plo_reg[2] == '0)
        else $error("degenerate item with nonzero numerator");

    // pipe frozen while a result waits
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(c_valid[QW]) && $stable(s6_valid_reg))
        else $error("pipe moved during output stall");

endmodule

`default_nettype wire
